FILE: src/sfm_pkg.sv
// Shared types and constants for the single-precision multiplier.
package sfm_pkg;
    localparam logic [9:0] BiasCarry = 10'd126;
    localparam logic [9:0] BiasPlain = 10'd127;
    localparam logic [9:0] ExpInf = 10'd255;
    localparam logic [31:0] InfBits = 32'h7f80_0000;

    // fields carried from the unpack stage to the multiply stage
    typedef struct packed {
        logic        sign;
        logic [9:0]  exp_sum;
        logic [23:0] sig_a;
        logic [23:0] sig_b;
    } t_unpacked;
endpackage

FILE: src/sfm_round.sv
// Normalize, range check and round-to-nearest-even of a 48-bit significand product.
module sfm_round
    import sfm_pkg::*;
(
    input  logic        i_sign,
    input  logic [9:0]  i_exp_sum,
    input  logic [47:0] i_prod,
    output logic [31:0] o_result
);
    logic [9:0]  exp_adj;
    logic [22:0] frac;
    logic        guard;
    logic        sticky;
    logic        inc;

    // one-place normalize and exponent bias
    always_comb begin
        if (i_prod[47]) begin
            exp_adj = i_exp_sum - BiasCarry;
            frac    = i_prod[46:24];
            guard   = i_prod[23];
            sticky  = |i_prod[22:0];
        end else begin
            exp_adj = i_exp_sum - BiasPlain;
            frac    = i_prod[45:23];
            guard   = i_prod[22];
            sticky  = |i_prod[21:0];
        end
        inc = guard & (sticky | frac[0]);
    end

    // underflow to zero, overflow to infinity, else rounded pack
    always_comb begin
        if (exp_adj[9]) begin
            o_result = {i_sign, 31'd0};
        end else if (exp_adj >= ExpInf) begin
            o_result = {i_sign, 31'd0} | InfBits;
        end else begin
            o_result = {i_sign, 31'd0} + {1'b0, exp_adj[7:0], frac} + {31'd0, inc};
        end
    end
endmodule

FILE: src/single_float_multiply.sv
// Top level of the pipelined single-precision multiplier.
// Usage: present operands on i_operand_a/i_operand_b with i_valid; a request is
// taken when i_valid and o_ready are both high. Results leave on o_product with
// o_valid and are taken when i_ready is high.
// Pipeline: unpack, 24x24 multiply, round into the output register; one new request
// accepted every cycle unless the output stalls. The 24x24 product
// register sets the critical stage.
// No classification of zero, infinity or NaN; denormals read as normals.
// Reset clears the stage valid bits only; payload registers are not reset.
// When the receiver stalls, a stage advances only if the stage ahead is empty
// or moving, so bubbles are squeezed out and nothing is lost or repeated.
// o_ready is low only when all stages hold items and the output is blocked.
module single_float_multiply
    import sfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_product
);
    logic        r_v1, r_v2, r_v3;
    t_unpacked   r_s1;
    logic        r_sign2;
    logic [9:0]  r_exp2;
    logic [47:0] r_prod2;
    logic [31:0] r_res3;
    logic [31:0] round_res;
    logic        adv3, adv2, adv1, adv0;

    // stall chain from output back to input
    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign adv0    = adv1;
    assign o_ready = adv0;

    sfm_round u_round (
        .i_sign    (r_sign2),
        .i_exp_sum (r_exp2),
        .i_prod    (r_prod2),
        .o_result  (round_res)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1.sign    <= i_operand_a[31] ^ i_operand_b[31];
            r_s1.exp_sum <= {2'b00, i_operand_a[30:23]} + {2'b00, i_operand_b[30:23]};
            r_s1.sig_a   <= {1'b1, i_operand_a[22:0]};
            r_s1.sig_b   <= {1'b1, i_operand_b[22:0]};
        end
        if (adv2) begin
            r_sign2 <= r_s1.sign;
            r_exp2  <= r_s1.exp_sum;
            r_prod2 <= r_s1.sig_a * r_s1.sig_b;
        end
        if (adv3) r_res3 <= round_res;
    end

    assign o_valid   = r_v3;
    assign o_product = r_res3;

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_product))
        else $error("stalled result changed");
    // the input is blocked only with a full pipeline
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_v1 && r_v2 && r_v3 && !i_ready)
        else $error("ready dropped with room in pipeline");
    // an accepted request is in stage one next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v1)
        else $error("accepted request lost");
endmodule

FILE: tb/single_float_multiply_test.sv
// Self-checking testbench for the pipelined single-precision multiplier.
`timescale 1ns / 100ps

module single_float_multiply_test;
    import sfm_pkg::*;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } t_operands;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_operand_a;
    logic [31:0] i_operand_b;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_product;

    t_operands   pending_q[$];
    logic [31:0] product_q[$];
    int          errors;
    bit          stim_done;
    int          hold_cycles;
    int          send_gap;
    int          recv_gap;
    bit          in_taken;

    single_float_multiply i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_operand_a(i_operand_a),
        .i_operand_b(i_operand_b),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_product  (o_product)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // rounded product of two single-precision patterns, no classification
    function automatic logic [31:0] fmul_expected(logic [31:0] a, logic [31:0] b);
        logic        sgn;
        logic [47:0] p;
        int          e;
        logic [22:0] frac;
        logic        guard;
        logic        sticky;
        logic        inc;
        sgn = a[31] ^ b[31];
        p = {1'b1, a[22:0]} * {1'b1, b[22:0]};
        if (p[47]) begin
            e = int'(a[30:23]) + int'(b[30:23]) - int'(BiasCarry);
            frac = p[46:24];
            guard = p[23];
            sticky = |p[22:0];
        end else begin
            e = int'(a[30:23]) + int'(b[30:23]) - int'(BiasPlain);
            frac = p[45:23];
            guard = p[22];
            sticky = |p[21:0];
        end
        if (e < 0) return {sgn, 31'd0};
        if (e >= int'(ExpInf)) return {sgn, 31'd0} | InfBits;
        inc = guard & (sticky | frac[0]);
        return {sgn, 31'd0} + ({24'd0, e[7:0]} << 23) + {9'd0, frac} + {31'd0, inc};
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [31:0] rand_float();
        // mostly exponents near the bias so products stay finite
        case ($urandom_range(0, 3))
            0: return $urandom;
            default: return {1'(($urandom)), 8'($urandom_range(100, 154)), 23'($urandom)};
        endcase
    endfunction

    // request handshake seen at the rising edge
    always @(posedge i_clk) begin
        in_taken <= i_valid && o_ready;
    end

    // request driver: changes on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            // hold current request
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            i_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
            i_valid <= 1'b1;
            i_operand_a <= pending_q[0].a;
            i_operand_b <= pending_q[0].b;
            product_q.push_back(fmul_expected(pending_q[0].a, pending_q[0].b));
            void'(pending_q.pop_front());
            send_gap <= pick_gap();
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver ready, with one long hold-off early on
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            recv_gap <= pick_gap();
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (product_q.size() == 0) begin
                $display("%0t: unexpected product, expected none, actual %h", $time,
                         o_product);
                errors <= errors + 1;
            end else begin
                if (o_product !== product_q[0]) begin
                    $display("%0t: product expected %h, actual %h", $time, product_q[0],
                             o_product);
                    errors <= errors + 1;
                end
                void'(product_q.pop_front());
            end
        end
    end

    initial begin
        logic [31:0] edge_vals[12];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_operand_a = '0;
        i_operand_b = '0;
        errors = 0;
        stim_done = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        hold_cycles = 0;
        edge_vals = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hffff_ffff,
                      32'h3f80_0000, 32'h3fc0_0000, 32'h7f7f_ffff, 32'h0080_0000,
                      32'h3f80_0001, 32'h4000_0000, 32'h1f80_0000, 32'h7fff_ffff};
        // directed: field extremes, underflow, overflow, exponent zero, carries
        pending_q.push_back('{32'h0000_0000, 32'h0000_0000});
        pending_q.push_back('{32'hffff_ffff, 32'hffff_ffff});
        pending_q.push_back('{32'h3f80_0000, 32'hbf80_0000});
        pending_q.push_back('{32'h1f80_0000, 32'h1f80_0000});  // underflow to zero
        pending_q.push_back('{32'h3f80_0000, 32'h0000_0000});  // exponent exactly zero
        pending_q.push_back('{32'h7f00_0000, 32'h4000_0000});  // overflow
        pending_q.push_back('{32'h7f7f_ffff, 32'h3f80_0001});  // product carry overflows to inf
        pending_q.push_back('{32'h3fff_ffff, 32'h3fff_ffff});  // normalize shift
        pending_q.push_back('{32'h3f80_0001, 32'h3f80_0001});  // rounding cases
        pending_q.push_back('{32'h3fc0_0000, 32'h3fc0_0001});
        pending_q.push_back('{32'h3f7f_ffff, 32'h3f80_0001});  // product carry into exponent
        for (int i = 0; i < 12; i++)
            pending_q.push_back('{edge_vals[i], edge_vals[11 - i]});
        for (int i = 0; i < 1500; i++)
            pending_q.push_back('{rand_float(), rand_float()});
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // long receiver stall while requests keep coming
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
        hold_cycles = 60;
        wait (pending_q.size() == 0 && product_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && product_q.size() == 0) begin
            $display("single_float_multiply: match");
        end else begin
            $display("single_float_multiply: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("single_float_multiply: mismatch");
        $finish;
    end
endmodule
